### design/line_component_tracker_macros.svh
// Assertion macros shared by the checkers of the line component tracker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LINE_COMPONENT_TRACKER_MACROS_SVH
`define LINE_COMPONENT_TRACKER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LCT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lct_pkg.sv
`default_nettype none

package lct_pkg;

    // Width of the position field.
    localparam int POS_W = 10;

    // Width of the count, size and line-width fields.
    localparam int CNT_W = 11;

    // Default number of cells on the line.
    localparam int MAX_POSITIONS_DEF = 1024;

    // Value of the line-width register after reset.
    localparam logic [CNT_W-1:0] WIDTH_RESET = 11'd1024;

endpackage

`default_nettype wire

### design/line_component_tracker.sv
`default_nettype none

// Marks cells on a line as occupied and tracks runs of occupied cells with a
// disjoint-set store held in one single-port-read memory. After every start
// transaction the block shows, for one cycle under done, the number of
// separate runs, the largest run seen so far and a rejected flag; the receiver
// cannot stall and must take the result in that cycle. After reset the block
// clears its memory, one entry a cycle, with busy high. A rejected transaction
// goes from S_SELF straight back to idle, and done is registered from that step.
// An accepted cell is written in S_SELF; then, for each occupied neighbor, the
// block walks its parent links, one memory read per link, rewrites the path,
// one memory write per node, and joins the two runs in S_JOIN1 and S_JOIN2;
// with path compression a join usually follows one or two links. A new cell is
// taken only once the block is back in idle.
// width_in_use may be written whenever busy is low; cfg_ready is always high.
module line_component_tracker #(
    parameter int MAX_POSITIONS = lct_pkg::MAX_POSITIONS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [lct_pkg::POS_W-1:0] position,
    output logic                           done,
    output logic [lct_pkg::CNT_W-1:0]      group_count,
    output logic [lct_pkg::CNT_W-1:0]      largest_group,
    output logic                           rejected,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [lct_pkg::CNT_W-1:0] width_in_use
);

    localparam int AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int SW = $clog2(MAX_POSITIONS + 1);
    localparam int CW = lct_pkg::CNT_W;
    localparam int LW = ((AW + 1) > CW) ? (AW + 1) : CW;

    typedef struct packed {
        logic          occ;
        logic [AW-1:0] parent;
        logic [SW-1:0] size;
    } entry_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SELF,
        S_NBR,
        S_WALK,
        S_COMP,
        S_JOIN1,
        S_JOIN2,
        S_RIGHT
    } state_t;

    entry_t mem [MAX_POSITIONS];
    entry_t rd_q;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wa;
    entry_t        wd;

    state_t        state_reg,      state_next;
    logic [AW-1:0] pos_reg,        pos_next;
    logic          rng_bad_reg,    rng_bad_next;
    logic [AW-1:0] cur_reg,        cur_next;
    logic [AW-1:0] head_reg,       head_next;
    logic          side_reg,       side_next;
    logic [AW-1:0] root_reg,       root_next;
    logic [SW-1:0] rsize_reg,      rsize_next;
    logic [AW-1:0] keep_reg,       keep_next;
    logic [SW-1:0] keep_size_reg,  keep_size_next;
    logic [AW-1:0] child_reg,      child_next;
    logic [SW-1:0] child_size_reg, child_size_next;
    logic [AW-1:0] ra_reg,         ra_next;
    logic [SW-1:0] ra_size_reg,    ra_size_next;
    logic [SW-1:0] groups_reg,     groups_next;
    logic [SW-1:0] largest_reg,    largest_next;
    logic          done_reg,       done_next;
    logic          rej_reg,        rej_next;
    logic [AW-1:0] clr_reg,        clr_next;
    logic [CW-1:0] width_reg;

    logic [LW-1:0] wid_ext;
    logic [LW-1:0] eff_width;
    logic          right_ok;
    logic [SW-1:0] sum_size;

    assign wid_ext   = LW'(width_reg);
    assign eff_width = (wid_ext > LW'(MAX_POSITIONS)) ? LW'(MAX_POSITIONS) : wid_ext;
    assign right_ok  = (LW'(pos_reg) + LW'(1)) < eff_width;
    assign sum_size  = keep_size_reg + child_size_reg;

    // Memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_q <= mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        rng_bad_next    = rng_bad_reg;
        cur_next        = cur_reg;
        head_next       = head_reg;
        side_next       = side_reg;
        root_next       = root_reg;
        rsize_next      = rsize_reg;
        keep_next       = keep_reg;
        keep_size_next  = keep_size_reg;
        child_next      = child_reg;
        child_size_next = child_size_reg;
        ra_next         = ra_reg;
        ra_size_next    = ra_size_reg;
        groups_next     = groups_reg;
        largest_next    = largest_reg;
        rej_next        = rej_reg;
        clr_next        = clr_reg;
        rd_addr         = cur_reg;
        we              = 1'b0;
        wa              = cur_reg;
        wd              = '0;

        case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                wa       = clr_reg;
                wd       = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_POSITIONS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                rd_addr = AW'(position);
                if (start)
                begin
                    pos_next     = AW'(position);
                    rng_bad_next = !(LW'(position) < eff_width);
                    state_next   = S_SELF;
                end
            end

            S_SELF:
            begin
                if (rng_bad_reg || rd_q.occ)
                begin
                    rej_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rej_next     = 1'b0;
                    we           = 1'b1;
                    wa           = pos_reg;
                    wd           = '{occ: 1'b1, parent: pos_reg, size: SW'(1)};
                    groups_next  = groups_reg + SW'(1);
                    if (largest_reg == '0)
                    begin
                        largest_next = SW'(1);
                    end
                    ra_next      = pos_reg;
                    ra_size_next = SW'(1);
                    if (pos_reg != '0)
                    begin
                        rd_addr    = pos_reg - AW'(1);
                        cur_next   = pos_reg - AW'(1);
                        head_next  = pos_reg - AW'(1);
                        side_next  = 1'b0;
                        state_next = S_NBR;
                    end
                    else
                    begin
                        state_next = S_RIGHT;
                    end
                end
            end

            S_RIGHT:
            begin
                if (right_ok)
                begin
                    rd_addr    = pos_reg + AW'(1);
                    cur_next   = pos_reg + AW'(1);
                    head_next  = pos_reg + AW'(1);
                    side_next  = 1'b1;
                    state_next = S_NBR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // The neighbor's entry is on rd_q; if it is occupied, its link
            // walk starts right away, one parent link per cycle.
            S_NBR, S_WALK:
            begin
                if ((state_reg == S_NBR) && !rd_q.occ)
                begin
                    state_next = side_reg ? S_IDLE : S_RIGHT;
                end
                else if (rd_q.parent == cur_reg)
                begin
                    root_next  = cur_reg;
                    rsize_next = rd_q.size;
                    rd_addr    = head_reg;
                    cur_next   = head_reg;
                    state_next = S_COMP;
                end
                else
                begin
                    rd_addr    = rd_q.parent;
                    cur_next   = rd_q.parent;
                    state_next = S_WALK;
                end
            end

            // Second pass over the path points every node straight at the root.
            S_COMP:
            begin
                if ((cur_reg == root_reg) || (rd_q.parent == root_reg))
                begin
                    if (!side_reg)
                    begin
                        keep_next       = root_reg;
                        keep_size_next  = rsize_reg;
                        child_next      = pos_reg;
                        child_size_next = SW'(1);
                    end
                    else
                    begin
                        keep_next       = ra_reg;
                        keep_size_next  = ra_size_reg;
                        child_next      = root_reg;
                        child_size_next = rsize_reg;
                    end
                    state_next = S_JOIN1;
                end
                else
                begin
                    we       = 1'b1;
                    wa       = cur_reg;
                    wd       = '{occ: 1'b1, parent: root_reg, size: rd_q.size};
                    rd_addr  = rd_q.parent;
                    cur_next = rd_q.parent;
                end
            end

            S_JOIN1:
            begin
                we         = 1'b1;
                wa         = child_reg;
                wd         = '{occ: 1'b1, parent: keep_reg, size: child_size_reg};
                state_next = S_JOIN2;
            end

            S_JOIN2:
            begin
                we           = 1'b1;
                wa           = keep_reg;
                wd           = '{occ: 1'b1, parent: keep_reg, size: sum_size};
                groups_next  = groups_reg - SW'(1);
                if (sum_size > largest_reg)
                begin
                    largest_next = sum_size;
                end
                ra_next      = keep_reg;
                ra_size_next = sum_size;
                state_next   = side_reg ? S_IDLE : S_RIGHT;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        done_next = (state_next == S_IDLE) && (state_reg != S_IDLE)
                    && (state_reg != S_CLEAR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            groups_reg  <= '0;
            largest_reg <= '0;
            done_reg    <= 1'b0;
            rej_reg     <= 1'b0;
            width_reg   <= lct_pkg::WIDTH_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            groups_reg  <= groups_next;
            largest_reg <= largest_next;
            done_reg    <= done_next;
            rej_reg     <= rej_next;
            if (cfg_valid && cfg_ready)
            begin
                width_reg <= width_in_use;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        rng_bad_reg    <= rng_bad_next;
        cur_reg        <= cur_next;
        head_reg       <= head_next;
        side_reg       <= side_next;
        root_reg       <= root_next;
        rsize_reg      <= rsize_next;
        keep_reg       <= keep_next;
        keep_size_reg  <= keep_size_next;
        child_reg      <= child_next;
        child_size_reg <= child_size_next;
        ra_reg         <= ra_next;
        ra_size_reg    <= ra_size_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign rejected      = rej_reg;
    assign group_count   = CW'(groups_reg);
    assign largest_group = CW'(largest_reg);
    assign cfg_ready     = 1'b1;

endmodule

`default_nettype wire

### design/lct_checker.sv
`default_nettype none

`include "line_component_tracker_macros.svh"

module lct_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      done,
    input wire logic [lct_pkg::CNT_W-1:0] group_count,
    input wire logic [lct_pkg::CNT_W-1:0] largest_group,
    input wire logic                      rejected
);

    // A result is only shown once the block has returned to idle.
    `LCT_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while busy")

    // An accepted transaction always makes the block busy.
    `LCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted start did not raise busy")

    // A rejected transaction leaves the counts untouched.
    `LCT_ASSERT_SAME(a_reject_keeps, done && rejected,
        $stable(group_count) && $stable(largest_group), "rejected item changed the counts")

    // Without a transaction in progress the counts cannot move.
    `LCT_ASSERT_NEXT(a_idle_hold, !busy && !start,
        $stable(group_count) && $stable(largest_group), "counts changed while idle")

endmodule

bind line_component_tracker lct_checker u_lct_checker (.*);

`default_nettype wire
